// File: hw/rtl/itp_pkg.sv
// itp_pkg: shared types, character codes and classification helpers
// for the infix to postfix converter. No dependencies.
package itp_pkg;

  // character codes
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;

  // precedence ranks; rank order matches the signed precedence order
  localparam logic [1:0] RANK_NONE = 2'd0;
  localparam logic [1:0] RANK_ADD  = 2'd1;
  localparam logic [1:0] RANK_MUL  = 2'd2;
  localparam logic [1:0] RANK_POW  = 2'd3;

  typedef enum logic [1:0] {
    KIND_LETTER,
    KIND_LPAREN,
    KIND_RPAREN,
    KIND_OP
  } kind_e;

  typedef struct packed {
    logic [7:0] in_char;
    logic       end_flag;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic       overflow;
    logic       run_last;
    logic       expression_end;
  } out_item_t;

  // classified character handed from front to back
  typedef struct packed {
    logic [7:0] ch;
    kind_e      kind;
    logic [1:0] rank;
    logic       last;
  } tok_t;

  function automatic logic [1:0] prec_rank(input logic [7:0] c);
    logic [1:0] r;
    if (c == CH_CARET) begin
      r = RANK_POW;
    end else if (c == CH_STAR || c == CH_SLASH) begin
      r = RANK_MUL;
    end else if (c == CH_PLUS || c == CH_MINUS) begin
      r = RANK_ADD;
    end else begin
      r = RANK_NONE;
    end
    return r;
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

endpackage

// File: hw/rtl/itp_fifo.sv
// itp_fifo: two-entry register queue used between pipeline parts.
// Depends on no package; the entry type is a parameter.
module itp_fifo #(
  parameter type item_t = logic
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  wr_i,
  input  item_t wdata_i,
  output logic  full_o,
  input  logic  rd_i,
  output item_t rdata_o,
  output logic  empty_o
);

  item_t       mem_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        do_wr, do_rd;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;

  // pointer and fill update
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_wr;
    rd_ptr_d = rd_ptr_q ^ do_rd;
    cnt_d    = cnt_q + {1'b0, do_wr} - {1'b0, do_rd};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// File: hw/rtl/itp_front.sv
// itp_front: accepts input characters, classifies them and queues them
// for the stack engine. Depends on itp_pkg and itp_fifo.
module itp_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  itp_pkg::in_item_t in_item_i,
  output itp_pkg::tok_t    tok_o,
  output logic             tok_empty_o,
  input  logic             tok_pop_i
);
  import itp_pkg::*;

  tok_t tok_in;

  // classify the incoming character
  always_comb begin
    tok_in.ch   = in_item_i.in_char;
    tok_in.rank = prec_rank(in_item_i.in_char);
    tok_in.last = in_item_i.end_flag;
    if (is_letter(in_item_i.in_char)) begin
      tok_in.kind = KIND_LETTER;
    end else if (in_item_i.in_char == CH_LPAREN) begin
      tok_in.kind = KIND_LPAREN;
    end else if (in_item_i.in_char == CH_RPAREN) begin
      tok_in.kind = KIND_RPAREN;
    end else begin
      tok_in.kind = KIND_OP;
    end
  end

  // queue toward the back end
  itp_fifo #(.item_t(tok_t)) u_tok_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (push_i),
    .wdata_i (tok_in),
    .full_o  (full_o),
    .rd_i    (tok_pop_i),
    .rdata_o (tok_o),
    .empty_o (tok_empty_o)
  );

endmodule

// File: hw/rtl/itp_back.sv
// itp_back: operator stack engine; pops one entry per cycle while the result
// queue has room and hands finished results to the result queue. Depends on itp_pkg.
module itp_back #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  itp_pkg::tok_t      tok_i,
  input  logic               tok_empty_i,
  output logic               tok_pop_o,
  output itp_pkg::out_item_t res_o,
  output logic               res_push_o,
  input  logic               res_full_i
);
  import itp_pkg::*;

  localparam int unsigned IW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_END  = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] count_m1;
  logic [IW-1:0] rd_idx;
  tok_t          cur_q, cur_d;
  out_item_t     pend_q, pend_d;
  logic          pend_v_q, pend_v_d;
  logic          byp_q, byp_d;
  logic [7:0]    bypc_q, bypc_d;
  logic [7:0]    rdata_q;
  logic [7:0]    stack_mem [STACK_DEPTH];
  logic          we;
  logic [IW-1:0] waddr;
  logic [7:0]    wdata;
  logic [7:0]    top;
  logic          gen_en;
  out_item_t     gen_item;

  // top of stack: a fresh push is bypassed until the memory read catches up
  assign top      = byp_q ? bypc_q : rdata_q;
  assign count_m1 = count_d - CW'(1);
  assign rd_idx   = count_m1[IW-1:0];

  // sequencer
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    cur_d      = cur_q;
    pend_d     = pend_q;
    pend_v_d   = pend_v_q;
    byp_d      = 1'b0;
    bypc_d     = bypc_q;
    tok_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res_o      = '0;
    we         = 1'b0;
    waddr      = count_q[IW-1:0];
    wdata      = cur_q.ch;
    gen_en     = 1'b0;
    gen_item   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (!tok_empty_i) begin
          tok_pop_o = 1'b1;
          cur_d     = tok_i;
          state_d   = S_RUN;
        end
      end
      S_RUN: begin
        if (!res_full_i) begin
          unique case (cur_q.kind)
            KIND_LETTER: begin
              gen_en              = 1'b1;
              gen_item.out_char   = cur_q.ch;
              gen_item.char_valid = 1'b1;
              state_d             = S_END;
            end
            KIND_RPAREN: begin
              if (count_q != '0 && top != CH_LPAREN) begin
                gen_en              = 1'b1;
                gen_item.out_char   = top;
                gen_item.char_valid = 1'b1;
                count_d             = count_q - CW'(1);
              end else begin
                if (count_q != '0) begin
                  count_d = count_q - CW'(1);
                end
                state_d = S_END;
              end
            end
            KIND_OP, KIND_LPAREN: begin
              if (cur_q.kind == KIND_OP && count_q != '0 &&
                  cur_q.rank <= prec_rank(top)) begin
                gen_en              = 1'b1;
                gen_item.out_char   = top;
                gen_item.char_valid = 1'b1;
                count_d             = count_q - CW'(1);
              end else begin
                if (count_q < DEPTH_C) begin
                  we      = 1'b1;
                  count_d = count_q + CW'(1);
                  byp_d   = 1'b1;
                  bypc_d  = cur_q.ch;
                end else begin
                  gen_en            = 1'b1;
                  gen_item.overflow = 1'b1;
                end
                state_d = S_END;
              end
            end
            default: state_d = S_END;
          endcase
        end else begin
          byp_d = byp_q;
        end
      end
      S_END: begin
        if (!res_full_i) begin
          if (cur_q.last && count_q != '0) begin
            // end of expression flush, top first
            gen_en              = 1'b1;
            gen_item.out_char   = top;
            gen_item.char_valid = 1'b1;
            count_d             = count_q - CW'(1);
          end else begin
            // close the step: mark the held result as its last
            if (pend_v_q) begin
              res_push_o            = 1'b1;
              res_o                 = pend_q;
              res_o.run_last        = 1'b1;
              res_o.expression_end  = cur_q.last;
              pend_v_d              = 1'b0;
            end else if (cur_q.last) begin
              res_push_o           = 1'b1;
              res_o.run_last       = 1'b1;
              res_o.expression_end = 1'b1;
            end
            state_d = S_IDLE;
          end
        end else begin
          byp_d = byp_q;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // a new result releases the one held before it
    if (gen_en) begin
      res_push_o = pend_v_q;
      res_o      = pend_q;
      pend_d     = gen_item;
      pend_v_d   = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      pend_v_q <= 1'b0;
      byp_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      pend_v_q <= pend_v_d;
      byp_q    <= byp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    pend_q <= pend_d;
    bypc_q <= bypc_d;
  end

  // operator stack memory, registered read of the next top entry
  always_ff @(posedge clk_i) begin
    if (we) begin
      stack_mem[waddr] <= wdata;
    end
    rdata_q <= stack_mem[rd_idx];
  end

endmodule

// File: hw/rtl/infix_to_postfix_converter.sv
// infix_to_postfix_converter: top level of the shunting-yard converter.
// Depends on itp_pkg, itp_front, itp_back and itp_fifo.
//
// Characters go in through a queue interface (push/full) and postfix
// results come out through another (empty/pop). A front end classifies each
// character and queues it; a stack engine then works on one character at a
// time and a two-entry result queue decouples it from the reader. Each character
// steps through the idle, run and end states of the stack engine, which pops one
// stack entry per cycle while the result queue has room (operators, ')' and the
// end-of-expression flush); one character pops at most STACK_DEPTH + 1 entries.
// Each character yields its results in order with run_last on its final result
// and expression_end on the final result of a marked last character.
module infix_to_postfix_converter #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  itp_pkg::in_item_t  in_item_i,
  output logic               empty,
  input  logic               pop,
  output itp_pkg::out_item_t res_o
);
  import itp_pkg::*;

  tok_t      tok;
  logic      tok_empty;
  logic      tok_pop;
  out_item_t res_data;
  logic      res_push;
  logic      res_full;

  // front end: classify and queue characters
  itp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .in_item_i   (in_item_i),
    .tok_o       (tok),
    .tok_empty_o (tok_empty),
    .tok_pop_i   (tok_pop)
  );

  // back end: operator stack engine
  itp_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_i       (tok),
    .tok_empty_i (tok_empty),
    .tok_pop_o   (tok_pop),
    .res_o       (res_data),
    .res_push_o  (res_push),
    .res_full_i  (res_full)
  );

  // result queue toward the reader
  itp_fifo #(.item_t(out_item_t)) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (res_push),
    .wdata_i (res_data),
    .full_o  (res_full),
    .rd_i    (pop),
    .rdata_o (res_o),
    .empty_o (empty)
  );

endmodule

// File: hw/rtl/itp_checker.sv
// itp_port_checks: port-level checks for the infix to postfix converter,
// bound to the top level. Depends on itp_pkg.
module itp_port_checks (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               push,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input itp_pkg::out_item_t res_o
);

  // no result is offered while in reset
  a_empty_in_reset: assert property (@(posedge clk_i) !rst_ni |-> empty)
    else $error("result offered during reset");

  // end of expression is always the last result of its character
  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && res_o.expression_end) |-> res_o.run_last)
    else $error("expression_end without run_last");

  // a result without a character carries a zero byte
  a_zero_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !res_o.char_valid) |-> (res_o.out_char == 8'h00))
    else $error("non-zero out_char on a result without a character");

  // an overflow report never carries a character
  a_ovf_no_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && res_o.overflow) |-> !res_o.char_valid)
    else $error("overflow result carries a character");

  // a waiting result holds until transferred
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(res_o)))
    else $error("waiting result changed before transfer");

endmodule

bind infix_to_postfix_converter itp_port_checks u_itp_port_checks (.*);

// File: tb/itp_checker.sv
// itp_checker: watches both queue ports of the infix to postfix converter,
// predicts the postfix output with its own operator stack and compares.
// Depends on itp_pkg for the item types and the character codes.
`timescale 1ns / 100ps

module itp_checker #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic               full_i,
  input  itp_pkg::in_item_t  in_item_i,
  input  logic               empty_i,
  input  logic               pop_i,
  input  itp_pkg::out_item_t res_i,
  output int                 fail_count_o,
  output int                 pending_o
);
  import itp_pkg::*;

  localparam logic [7:0] LOWER_FIRST = 8'h61;
  localparam logic [7:0] LOWER_LAST  = 8'h7A;
  localparam logic [7:0] UPPER_FIRST = 8'h41;
  localparam logic [7:0] UPPER_LAST  = 8'h5A;
  localparam int         MAX_LINES   = 50;

  // predicted operator stack and the postfix results still owed
  logic [7:0] op_stack [STACK_DEPTH];
  int unsigned stack_fill;
  out_item_t   step_res [$];
  out_item_t   postfix_q [$];

  initial begin
    stack_fill   = 0;
    fail_count_o = 0;
    pending_o    = 0;
  end

  function automatic int op_rank(input logic [7:0] c);
    if (c == CH_CARET) begin
      return 3;
    end else if (c == CH_STAR || c == CH_SLASH) begin
      return 2;
    end else if (c == CH_PLUS || c == CH_MINUS) begin
      return 1;
    end
    return -1;
  endfunction

  function automatic out_item_t make_res(input logic [7:0] ch, input logic valid,
                                         input logic ovf);
    out_item_t r;
    r            = '0;
    r.out_char   = valid ? ch : 8'h00;
    r.char_valid = valid;
    r.overflow   = ovf;
    return r;
  endfunction

  // pop the top entry and emit it
  task automatic pop_emit();
    stack_fill = stack_fill - 1;
    step_res.push_back(make_res(op_stack[stack_fill], 1'b1, 1'b0));
  endtask

  // push, or report the dropped byte when the stack is full
  task automatic push_op(input logic [7:0] c);
    if (stack_fill >= STACK_DEPTH) begin
      step_res.push_back(make_res(8'h00, 1'b0, 1'b1));
    end else begin
      op_stack[stack_fill] = c;
      stack_fill = stack_fill + 1;
    end
  endtask

  // shunting-yard step for one accepted character
  task automatic convert_char(input in_item_t it);
    logic [7:0] c;
    int         p;
    c = it.in_char;
    step_res.delete();
    if ((c >= LOWER_FIRST && c <= LOWER_LAST) || (c >= UPPER_FIRST && c <= UPPER_LAST)) begin
      step_res.push_back(make_res(c, 1'b1, 1'b0));
    end else if (c == CH_LPAREN) begin
      push_op(c);
    end else if (c == CH_RPAREN) begin
      while (stack_fill > 0 && op_stack[stack_fill - 1] != CH_LPAREN) begin
        pop_emit();
      end
      // drop the matching open paren, if any
      if (stack_fill > 0) begin
        stack_fill = stack_fill - 1;
      end
    end else begin
      p = op_rank(c);
      while (stack_fill > 0 && p <= op_rank(op_stack[stack_fill - 1])) begin
        pop_emit();
      end
      push_op(c);
    end
    // end of expression flushes the whole stack
    if (it.end_flag) begin
      while (stack_fill > 0) begin
        pop_emit();
      end
      if (step_res.size() == 0) begin
        step_res.push_back(make_res(8'h00, 1'b0, 1'b0));
      end
      step_res[step_res.size() - 1].expression_end = 1'b1;
    end
    if (step_res.size() > 0) begin
      step_res[step_res.size() - 1].run_last = 1'b1;
    end
    foreach (step_res[i]) begin
      postfix_q.push_back(step_res[i]);
    end
  endtask

  task automatic report_mismatch(input string what, input out_item_t got,
                                 input out_item_t want);
    fail_count_o = fail_count_o + 1;
    if (fail_count_o <= MAX_LINES) begin
      $display("%0t itp_checker: %s: got %02h/v%0b/o%0b/l%0b/e%0b want %02h/v%0b/o%0b/l%0b/e%0b",
               $time, what, got.out_char, got.char_valid, got.overflow, got.run_last,
               got.expression_end, want.out_char, want.char_valid, want.overflow,
               want.run_last, want.expression_end);
    end
  endtask

  // compare one result transfer with the oldest prediction
  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (postfix_q.size() == 0) begin
      report_mismatch("result with nothing pending", got, '0);
    end else begin
      want = postfix_q.pop_front();
      if (got.out_char != want.out_char) begin
        report_mismatch("out_char differs", got, want);
      end else if (got.char_valid != want.char_valid) begin
        report_mismatch("char_valid differs", got, want);
      end else if (got.overflow != want.overflow) begin
        report_mismatch("overflow differs", got, want);
      end else if (got.run_last != want.run_last) begin
        report_mismatch("run_last differs", got, want);
      end else if (got.expression_end != want.expression_end) begin
        report_mismatch("expression_end differs", got, want);
      end
    end
  endtask

  // results first: a result leaving now stems from an earlier transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop_i && !empty_i) begin
        check_result(res_i);
      end
      if (push_i && !full_i) begin
        convert_char(in_item_i);
      end
      pending_o <= postfix_q.size();
    end
  end

endmodule

// File: tb/tb.sv
// tb: stimulus and verdict for the infix to postfix converter; the
// itp_checker instance predicts and compares. Depends on itp_pkg.
`timescale 1ns / 100ps

module tb;
  import itp_pkg::*;

  localparam int unsigned STACK_DEPTH  = 16;
  localparam int          RANDOM_ITEMS = 420;
  localparam int          HOLD_AT      = 100;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          PAUSE_AT     = 300;
  localparam int          SETTLE       = 2 * STACK_DEPTH + 32;
  localparam logic [7:0]  LETTER_LOWER = 8'h61;
  localparam logic [7:0]  LETTER_UPPER = 8'h41;

  typedef enum logic [1:0] {
    DRAIN_ALL,
    DRAIN_MOST,
    DRAIN_SPARSE,
    DRAIN_TOGGLE
  } drain_mode_e;

  logic      clk_i;
  logic      rst_ni;
  logic      push;
  logic      full;
  in_item_t  in_item;
  logic      empty;
  logic      pop;
  out_item_t res;
  int        fail_count;
  int        pending;
  int        items_sent;
  int        burst_left;

  logic [7:0] op_codes [5];

  infix_to_postfix_converter #(
    .STACK_DEPTH(STACK_DEPTH)
  ) dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .full     (full),
    .in_item_i(in_item),
    .empty    (empty),
    .pop      (pop),
    .res_o    (res)
  );

  itp_checker #(
    .STACK_DEPTH(STACK_DEPTH)
  ) checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_i      (full),
    .in_item_i   (in_item),
    .empty_i     (empty),
    .pop_i       (pop),
    .res_i       (res),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  // one character transfer; bursts with random gaps between them
  task automatic send_char(input logic [7:0] c, input logic last);
    in_item_t it;
    int       gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    it.in_char  = c;
    it.end_flag = last;
    push    <= 1'b1;
    in_item <= it;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    burst_left = burst_left - 1;
    items_sent = items_sent + 1;
  endtask

  // wait with push low until every predicted result has been taken
  task automatic drain_all();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // random well-formed expression, or a broken one
  task automatic send_expression(input int max_terms, input bit broken, input bit deep);
    logic [7:0] expr [$];
    logic [7:0] ltr;
    int         depth;
    int         terms;
    int         open_odds;
    depth     = 0;
    terms     = $urandom_range(1, max_terms);
    open_odds = deep ? 1 : 3;
    for (int i = 0; i < terms; i++) begin
      while (depth < 20 && $urandom_range(0, open_odds) == 0) begin
        expr.push_back(CH_LPAREN);
        depth++;
      end
      ltr = 8'($urandom_range(0, 25));
      expr.push_back(($urandom_range(0, 1) ? LETTER_LOWER : LETTER_UPPER) + ltr);
      while (depth > 0 && $urandom_range(0, 2) == 0) begin
        expr.push_back(CH_RPAREN);
        depth--;
      end
      if (i < terms - 1) begin
        expr.push_back(op_codes[$urandom_range(0, 4)]);
      end
    end
    if (!broken) begin
      while (depth > 0) begin
        expr.push_back(CH_RPAREN);
        depth--;
      end
    end else begin
      // stray paren, dangling operator or a junk byte somewhere
      case ($urandom_range(0, 2))
        0: expr.push_back(CH_RPAREN);
        1: expr.push_back(op_codes[$urandom_range(0, 4)]);
        default: expr.insert($urandom_range(0, expr.size()), 8'($urandom_range(0, 255)));
      endcase
    end
    foreach (expr[i]) begin
      send_char(expr[i], i == expr.size() - 1);
    end
  endtask

  // stimulus
  initial begin
    int  goal;
    int  pick;
    bit  paused;
    op_codes[0] = CH_CARET;
    op_codes[1] = CH_STAR;
    op_codes[2] = CH_SLASH;
    op_codes[3] = CH_PLUS;
    op_codes[4] = CH_MINUS;
    items_sent  = 0;
    burst_left  = 0;
    paused      = 1'b0;
    rst_ni  <= 1'b0;
    push    <= 1'b0;
    in_item <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: unmatched close on an empty stack, letter extremes,
    // left-associative caret, other bytes, unmatched close with entries
    send_char(CH_RPAREN, 1'b0);
    send_char(LETTER_LOWER, 1'b0);
    send_char(CH_CARET, 1'b0);
    send_char(LETTER_UPPER + 8'd25, 1'b0);
    send_char(CH_CARET, 1'b0);
    send_char(8'h00, 1'b0);
    send_char(CH_RPAREN, 1'b0);
    send_char(8'hFF, 1'b1);
    // end of expression with nothing to emit
    send_char(CH_RPAREN, 1'b1);
    // fill the stack with parens and every operator, then overflow on the end
    for (int i = 0; i < STACK_DEPTH / 2; i++) begin
      send_char(CH_LPAREN, 1'b0);
      send_char(op_codes[i % 5], 1'b0);
    end
    send_char(CH_LPAREN, 1'b1);
    drain_all();

    // random expressions, mostly well formed
    goal = items_sent + RANDOM_ITEMS;
    while (items_sent < goal) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        send_expression(6, 1'b0, 1'b0);
      end else if (pick < 7) begin
        send_expression(16, 1'b0, 1'b1);
      end else if (pick < 8) begin
        send_expression(6, 1'b1, 1'b0);
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        end
      end
      if (!paused && items_sent >= PAUSE_AT) begin
        paused = 1'b1;
        drain_all();
      end
    end

    drain_all();
    repeat (SETTLE) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // result side: stall pattern of its own plus one long hold-off
  initial begin
    drain_mode_e mode;
    int          mode_left;
    int          hold_left;
    bit          held;
    mode      = DRAIN_ALL;
    mode_left = 0;
    hold_left = 0;
    held      = 1'b0;
    pop <= 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      @(posedge clk_i);
      if (!held && items_sent >= HOLD_AT) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        pop <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = drain_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 100);
        end
        mode_left = mode_left - 1;
        case (mode)
          DRAIN_ALL:    pop <= 1'b1;
          DRAIN_MOST:   pop <= ($urandom_range(0, 3) != 0);
          DRAIN_SPARSE: pop <= ($urandom_range(0, 3) == 0);
          default:      pop <= mode_left[0];
        endcase
      end
    end
  end

endmodule
